@@ hw/rtl/aabb_eot_pkg.sv @@
`default_nettype none
package aabb_eot_pkg;

    localparam int ACT_W     = 2;
    localparam int SLOT_IN_W = 10;
    localparam int IN_W      = 24;
    localparam int CNT_FW    = 7;

    localparam logic [ACT_W-1:0] ACT_LINK   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_UNLINK = 2'd1;
    localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd2;

    typedef struct packed {
        logic clear;
        logic link;
        logic unlink;
        logic start;
        logic scan;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic scan_done;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

@@ hw/rtl/aabb_eot_ctrl.sv @@
`default_nettype none
module aabb_eot_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic [aabb_eot_pkg::ACT_W-1:0] action,
    output logic                               in_stall,
    input  wire aabb_eot_pkg::status_t          status,
    output aabb_eot_pkg::cmd_t                  cmd
);
    import aabb_eot_pkg::*;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (action)
                        ACT_LINK:   cmd.link   = 1'b1;
                        ACT_UNLINK: cmd.unlink = 1'b1;
                        ACT_QUERY:
                        begin
                            cmd.start  = 1'b1;
                            state_next = S_SCAN;
                        end
                        default:    cmd = '0;
                    endcase
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_done && status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    // beats are taken only between queries and after the flag clear
    assign in_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/aabb_eot_dp.sv @@
`default_nettype none
module aabb_eot_dp #(
    parameter int SLOTS      = 1024,
    parameter int COORD_BITS = 24,
    parameter int MAX_HITS   = 64
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire aabb_eot_pkg::cmd_t                     cmd,
    output aabb_eot_pkg::status_t                       status,
    input  wire logic        [aabb_eot_pkg::SLOT_IN_W-1:0] slot,
    input  wire logic signed [aabb_eot_pkg::IN_W-1:0]   origin_x,
    input  wire logic signed [aabb_eot_pkg::IN_W-1:0]   origin_y,
    input  wire logic signed [aabb_eot_pkg::IN_W-1:0]   origin_z,
    input  wire logic signed [aabb_eot_pkg::IN_W-1:0]   lo_x,
    input  wire logic signed [aabb_eot_pkg::IN_W-1:0]   lo_y,
    input  wire logic signed [aabb_eot_pkg::IN_W-1:0]   lo_z,
    input  wire logic signed [aabb_eot_pkg::IN_W-1:0]   hi_x,
    input  wire logic signed [aabb_eot_pkg::IN_W-1:0]   hi_y,
    input  wire logic signed [aabb_eot_pkg::IN_W-1:0]   hi_z,
    input  wire logic        [aabb_eot_pkg::CNT_FW-1:0] max_count,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic             [aabb_eot_pkg::SLOT_IN_W-1:0] slot_found,
    output logic                                        hit,
    output logic                                        last,
    output logic             [aabb_eot_pkg::CNT_FW-1:0] count
);
    import aabb_eot_pkg::*;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int IDX_CW = $clog2(SLOTS + 1);
    localparam int CW     = (COORD_BITS > IN_W) ? COORD_BITS : IN_W;
    localparam int SW     = (COORD_BITS > IN_W + 1) ? COORD_BITS : IN_W + 1;
    localparam int BOX_W  = 6 * COORD_BITS;
    localparam logic signed [SW-1:0] CMAX = SW'((longint'(1) << (COORD_BITS - 1)) - 1);
    localparam logic signed [SW-1:0] CMIN = ~CMAX;

    function automatic logic signed [COORD_BITS-1:0] sat_add(
        input logic signed [IN_W-1:0] a,
        input logic signed [IN_W-1:0] b
    );
        logic signed [SW-1:0] s;
        logic signed [SW-1:0] r;
        s = SW'(a) + SW'(b);
        if (s > CMAX)
        begin
            r = CMAX;
        end
        else if (s < CMIN)
        begin
            r = CMIN;
        end
        else
        begin
            r = s;
        end
        return COORD_BITS'(r);
    endfunction

    // box word: min x,y,z in the low three lanes, max x,y,z above
    logic             flag_mem [SLOTS];
    logic [BOX_W-1:0] box_mem  [SLOTS];

    logic             flag_rd_reg;
    logic [BOX_W-1:0] box_rd_reg;

    logic [IDX_CW-1:0]    idx_cnt_reg;
    logic [CNT_FW-1:0]    hits_reg;
    logic [CNT_FW-1:0]    limit_reg;
    logic                 s1_valid_reg;
    logic [SLOT_W-1:0]    s1_idx_reg;
    logic                 pend_valid_reg;
    logic [SLOT_W-1:0]    pend_idx_reg;
    logic [CNT_FW-1:0]    pend_cnt_reg;
    logic                 out_valid_reg;
    logic [SLOT_W-1:0]    out_slot_reg;
    logic                 out_hit_reg;
    logic                 out_last_reg;
    logic [CNT_FW-1:0]    out_cnt_reg;
    logic signed [CW-1:0] q_reg [6];

    logic signed [IN_W-1:0]       org   [3];
    logic signed [IN_W-1:0]       off   [6];
    logic signed [CW-1:0]         q_in  [6];
    logic signed [COORD_BITS-1:0] rd_c  [6];
    logic [BOX_W-1:0]             link_word;
    logic [2:0]                   axis_ok;
    logic                         slot_ok;
    logic [SLOT_W-1:0]            waddr;
    logic [SLOT_W-1:0]            raddr;
    logic [CNT_FW-1:0]            limit_next;
    logic [CNT_FW-1:0]            hits_inc;
    logic                         out_free;
    logic                         limit_hit;
    logic                         idx_end;
    logic                         match;
    logic                         s1_hold;
    logic                         take;
    logic                         issue;

    always_comb
    begin
        org[0] = origin_x;
        org[1] = origin_y;
        org[2] = origin_z;
        off[0] = lo_x;
        off[1] = lo_y;
        off[2] = lo_z;
        off[3] = hi_x;
        off[4] = hi_y;
        off[5] = hi_z;
        for (int a = 0; a < 6; a++)
        begin
            q_in[a]                             = CW'(off[a]);
            link_word[a*COORD_BITS +: COORD_BITS] = sat_add(org[a % 3], off[a]);
            rd_c[a]                             = box_rd_reg[a*COORD_BITS +: COORD_BITS];
        end
        // touching faces count as overlap
        for (int a = 0; a < 3; a++)
        begin
            axis_ok[a] = (CW'(rd_c[a]) <= q_reg[a + 3]) && (CW'(rd_c[a + 3]) >= q_reg[a]);
        end
    end

    assign slot_ok    = (32'(slot) < SLOTS);
    assign waddr      = SLOT_W'(slot);
    assign raddr      = idx_cnt_reg[SLOT_W-1:0];
    assign limit_next = (max_count > CNT_FW'(MAX_HITS)) ? CNT_FW'(MAX_HITS) : max_count;
    assign hits_inc   = hits_reg + 1'b1;

    assign out_free  = !out_valid_reg || !out_stall;
    assign limit_hit = (hits_reg == limit_reg);
    assign idx_end   = (idx_cnt_reg == IDX_CW'(SLOTS));
    assign match     = s1_valid_reg && flag_rd_reg && (&axis_ok) && !limit_hit;
    // a second hit can only move in once the held one has a place to go
    assign s1_hold   = match && pend_valid_reg && !out_free;
    assign take      = match && !s1_hold;
    assign issue     = cmd.scan && !idx_end && !limit_hit && !s1_hold;

    assign status.clear_last = (idx_cnt_reg == IDX_CW'(SLOTS - 1));
    assign status.scan_done  = limit_hit || (idx_end && !s1_valid_reg);
    assign status.out_free   = out_free;

    always_ff @(posedge clk)
    begin
        if (cmd.link && slot_ok)
        begin
            box_mem[waddr] <= link_word;
        end
        if (cmd.clear)
        begin
            flag_mem[raddr] <= 1'b0;
        end
        else if ((cmd.link || cmd.unlink) && slot_ok)
        begin
            flag_mem[waddr] <= cmd.link;
        end
        if (issue)
        begin
            flag_rd_reg <= flag_mem[raddr];
            box_rd_reg  <= box_mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_cnt_reg    <= '0;
            hits_reg       <= '0;
            limit_reg      <= '0;
            s1_valid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                idx_cnt_reg  <= '0;
                hits_reg     <= '0;
                limit_reg    <= limit_next;
                s1_valid_reg <= 1'b0;
            end
            else
            begin
                if (cmd.clear || issue)
                begin
                    idx_cnt_reg <= idx_cnt_reg + 1'b1;
                end
                if (take)
                begin
                    hits_reg <= hits_inc;
                end
                s1_valid_reg <= issue || s1_hold;
            end

            if (take)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.finish)
            begin
                pend_valid_reg <= 1'b0;
            end

            if ((take && pend_valid_reg) || cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            for (int a = 0; a < 6; a++)
            begin
                q_reg[a] <= q_in[a];
            end
        end
        if (issue)
        begin
            s1_idx_reg <= raddr;
        end
        if (take)
        begin
            pend_idx_reg <= s1_idx_reg;
            pend_cnt_reg <= hits_inc;
            if (pend_valid_reg)
            begin
                out_slot_reg <= pend_idx_reg;
                out_hit_reg  <= 1'b1;
                out_last_reg <= 1'b0;
                out_cnt_reg  <= pend_cnt_reg;
            end
        end
        else if (cmd.finish)
        begin
            // held hit closes the query; none held gives the empty beat
            out_slot_reg <= pend_valid_reg ? pend_idx_reg : '0;
            out_hit_reg  <= pend_valid_reg;
            out_last_reg <= 1'b1;
            out_cnt_reg  <= pend_valid_reg ? pend_cnt_reg : '0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign slot_found = SLOT_IN_W'(out_slot_reg);
    assign hit        = out_hit_reg;
    assign last       = out_last_reg;
    assign count      = out_cnt_reg;

`ifndef SYNTH
    a_hits_le_limit: assert property (@(posedge clk) disable iff (!rst_n)
        hits_reg <= limit_reg)
        else $error("hit count ran past the limit");

    a_limit_range: assert property (@(posedge clk) disable iff (!rst_n)
        limit_reg <= CNT_FW'(MAX_HITS))
        else $error("limit above MAX_HITS");

    a_empty_beat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_hit_reg |-> out_last_reg && (out_cnt_reg == '0))
        else $error("empty beat must be last with zero count");

    a_hold_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        s1_hold |=> s1_valid_reg && $stable(s1_idx_reg))
        else $error("held scan entry lost");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/aabb_entity_overlap_table.sv @@
// Link and unlink beats leave the controller idle; the next beat is taken the cycle after.
// A query scans the table through one memory read port, one slot a cycle, and stops
// once max_count hits (at most MAX_HITS) are found; a stalled output stalls the scan
// once a second hit waits. Results come one beat a cycle while out_stall is low.
// After reset the linked flags are cleared in a pass over all SLOTS slots; in_stall is high
// during it. Box corners have no reset.
`default_nettype none
module aabb_entity_overlap_table #(
    parameter int SLOTS      = 1024,
    parameter int COORD_BITS = 24,
    parameter int MAX_HITS   = 64
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic        [aabb_eot_pkg::ACT_W-1:0]  action,
    input  wire logic        [aabb_eot_pkg::SLOT_IN_W-1:0] slot,
    input  wire logic signed [aabb_eot_pkg::IN_W-1:0]   origin_x,
    input  wire logic signed [aabb_eot_pkg::IN_W-1:0]   origin_y,
    input  wire logic signed [aabb_eot_pkg::IN_W-1:0]   origin_z,
    input  wire logic signed [aabb_eot_pkg::IN_W-1:0]   lo_x,
    input  wire logic signed [aabb_eot_pkg::IN_W-1:0]   lo_y,
    input  wire logic signed [aabb_eot_pkg::IN_W-1:0]   lo_z,
    input  wire logic signed [aabb_eot_pkg::IN_W-1:0]   hi_x,
    input  wire logic signed [aabb_eot_pkg::IN_W-1:0]   hi_y,
    input  wire logic signed [aabb_eot_pkg::IN_W-1:0]   hi_z,
    input  wire logic        [aabb_eot_pkg::CNT_FW-1:0] max_count,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic             [aabb_eot_pkg::SLOT_IN_W-1:0] slot_found,
    output logic                                        hit,
    output logic                                        last,
    output logic             [aabb_eot_pkg::CNT_FW-1:0] count
);
    import aabb_eot_pkg::*;

    cmd_t    cmd;
    status_t status;

    aabb_eot_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .action   (action),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    aabb_eot_dp #(
        .SLOTS      (SLOTS),
        .COORD_BITS (COORD_BITS),
        .MAX_HITS   (MAX_HITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .slot       (slot),
        .origin_x   (origin_x),
        .origin_y   (origin_y),
        .origin_z   (origin_z),
        .lo_x       (lo_x),
        .lo_y       (lo_y),
        .lo_z       (lo_z),
        .hi_x       (hi_x),
        .hi_y       (hi_y),
        .hi_z       (hi_z),
        .max_count  (max_count),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .slot_found (slot_found),
        .hit        (hit),
        .last       (last),
        .count      (count)
    );

endmodule
`default_nettype wire

@@ bench/tb.sv @@
module tb;
    import aabb_eot_pkg::*;

    localparam int SLOTS       = 1024;
    localparam int COORD_BITS  = IN_W;
    localparam int MAX_HITS    = 64;
    localparam int COORD_MAX   = (1 << (COORD_BITS - 1)) - 1;
    localparam int COORD_MIN   = -COORD_MAX - 1;
    localparam int RANDOM_OPS  = 370;
    localparam int CYCLE_LIMIT = 4_000_000;

    localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;   // unused action code, ignored

    localparam logic signed [IN_W-1:0] C_MAX = {1'b0, {(IN_W-1){1'b1}}};
    localparam logic signed [IN_W-1:0] C_MIN = {1'b1, {(IN_W-1){1'b0}}};

    typedef struct packed {
        logic [ACT_W-1:0]       action;
        logic [SLOT_IN_W-1:0]   slot;
        logic signed [IN_W-1:0] origin_x;
        logic signed [IN_W-1:0] origin_y;
        logic signed [IN_W-1:0] origin_z;
        logic signed [IN_W-1:0] lo_x;
        logic signed [IN_W-1:0] lo_y;
        logic signed [IN_W-1:0] lo_z;
        logic signed [IN_W-1:0] hi_x;
        logic signed [IN_W-1:0] hi_y;
        logic signed [IN_W-1:0] hi_z;
        logic [CNT_FW-1:0]      max_count;
        logic                   drain;      // hold until all hit reports are back
    } table_op_t;

    typedef struct packed {
        logic [SLOT_IN_W-1:0] slot_found;
        logic                 hit;
        logic                 last;
        logic [CNT_FW-1:0]    count;
    } hit_report_t;

    logic clk;
    logic rst_n;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [ACT_W-1:0]       action    = '0;
    logic [SLOT_IN_W-1:0]   slot      = '0;
    logic signed [IN_W-1:0] origin_x  = '0;
    logic signed [IN_W-1:0] origin_y  = '0;
    logic signed [IN_W-1:0] origin_z  = '0;
    logic signed [IN_W-1:0] lo_x      = '0;
    logic signed [IN_W-1:0] lo_y      = '0;
    logic signed [IN_W-1:0] lo_z      = '0;
    logic signed [IN_W-1:0] hi_x      = '0;
    logic signed [IN_W-1:0] hi_y      = '0;
    logic signed [IN_W-1:0] hi_z      = '0;
    logic [CNT_FW-1:0]      max_count = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [SLOT_IN_W-1:0] slot_found;
    logic                 hit;
    logic                 last;
    logic [CNT_FW-1:0]    count;

    aabb_entity_overlap_table #(
        .SLOTS(SLOTS),
        .COORD_BITS(COORD_BITS),
        .MAX_HITS(MAX_HITS)
    ) uut (.*);

    // predicted table contents
    bit                     linked       [SLOTS];
    logic signed [IN_W-1:0] corner_min_x [SLOTS];
    logic signed [IN_W-1:0] corner_min_y [SLOTS];
    logic signed [IN_W-1:0] corner_min_z [SLOTS];
    logic signed [IN_W-1:0] corner_max_x [SLOTS];
    logic signed [IN_W-1:0] corner_max_y [SLOTS];
    logic signed [IN_W-1:0] corner_max_z [SLOTS];

    table_op_t   ops_waiting[$];
    table_op_t   on_bus;
    hit_report_t expected_hits[$];
    int hits_due   = 0;
    int hits_seen  = 0;
    int mismatches = 0;
    int send_idle  = 0;
    int recv_hold  = 0;
    int cycles     = 0;
    bit send_calm  = 1'b0;
    bit recv_calm  = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic signed [IN_W-1:0] clamp_sum(logic signed [IN_W-1:0] a,
                                                         logic signed [IN_W-1:0] b);
        int s;
        s = int'(a) + int'(b);
        if (s > COORD_MAX)
            s = COORD_MAX;
        else if (s < COORD_MIN)
            s = COORD_MIN;
        return s[IN_W-1:0];
    endfunction

    // Applies one accepted beat to the table copy; queues the query's reports.
    function automatic int predict_hits(table_op_t op);
        int          limit;
        int          n;
        hit_report_t r;
        n = 0;
        case (op.action)
            ACT_LINK:
            begin
                corner_min_x[op.slot] = clamp_sum(op.origin_x, op.lo_x);
                corner_min_y[op.slot] = clamp_sum(op.origin_y, op.lo_y);
                corner_min_z[op.slot] = clamp_sum(op.origin_z, op.lo_z);
                corner_max_x[op.slot] = clamp_sum(op.origin_x, op.hi_x);
                corner_max_y[op.slot] = clamp_sum(op.origin_y, op.hi_y);
                corner_max_z[op.slot] = clamp_sum(op.origin_z, op.hi_z);
                linked[op.slot] = 1'b1;
            end
            ACT_UNLINK:
                linked[op.slot] = 1'b0;
            ACT_QUERY:
            begin
                limit = (op.max_count > MAX_HITS) ? MAX_HITS : int'(op.max_count);
                for (int i = 0; i < SLOTS && n < limit; i++)
                begin
                    if (linked[i] &&
                        corner_min_x[i] <= op.hi_x && corner_min_y[i] <= op.hi_y &&
                        corner_min_z[i] <= op.hi_z &&
                        corner_max_x[i] >= op.lo_x && corner_max_y[i] >= op.lo_y &&
                        corner_max_z[i] >= op.lo_z)
                    begin
                        n++;
                        r.slot_found = i[SLOT_IN_W-1:0];
                        r.hit        = 1'b1;
                        r.last       = 1'b0;
                        r.count      = n[CNT_FW-1:0];
                        expected_hits.push_back(r);
                    end
                end
                if (n == 0)
                begin
                    r.slot_found = '0;
                    r.hit        = 1'b0;
                    r.last       = 1'b1;
                    r.count      = '0;
                    expected_hits.push_back(r);
                    n = 1;
                end
                else
                    expected_hits[expected_hits.size() - 1].last = 1'b1;
            end
            default: ;
        endcase
        return n;
    endfunction

    // wait length per beat; calm stretches have no idling at all
    function automatic int pace(inout bit calm);
        if ($urandom_range(0, 11) == 0)
            calm = !calm;
        return calm ? 0 : int'($urandom_range(0, 19));
    endfunction

    function automatic logic signed [IN_W-1:0] coord_in(int lo, int hi);
        int v;
        v = lo + int'($urandom_range(0, hi - lo));
        return v[IN_W-1:0];
    endfunction

    function automatic void push_uniform(logic [ACT_W-1:0] act, logic [SLOT_IN_W-1:0] s,
                                         logic signed [IN_W-1:0] o,
                                         logic signed [IN_W-1:0] l,
                                         logic signed [IN_W-1:0] h,
                                         logic [CNT_FW-1:0] mc);
        table_op_t op;
        op.action    = act;
        op.slot      = s;
        op.origin_x  = o;
        op.origin_y  = o;
        op.origin_z  = o;
        op.lo_x      = l;
        op.lo_y      = l;
        op.lo_z      = l;
        op.hi_x      = h;
        op.hi_y      = h;
        op.hi_z      = h;
        op.max_count = mc;
        op.drain     = 1'b0;
        ops_waiting.push_back(op);
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        int added;
        bit launch;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_idle = 0;
        end
        else
        begin
            added = 0;
            if (in_valid && !in_stall)
                added = predict_hits(on_bus);
            if (!in_valid || !in_stall)
            begin
                launch = 1'b0;
                if (send_idle > 0)
                    send_idle--;
                else if (ops_waiting.size() > 0 &&
                         (!ops_waiting[0].drain || hits_seen == hits_due + added))
                    launch = 1'b1;
                if (launch)
                begin
                    on_bus = ops_waiting.pop_front();
                    action    <= on_bus.action;
                    slot      <= on_bus.slot;
                    origin_x  <= on_bus.origin_x;
                    origin_y  <= on_bus.origin_y;
                    origin_z  <= on_bus.origin_z;
                    lo_x      <= on_bus.lo_x;
                    lo_y      <= on_bus.lo_y;
                    lo_z      <= on_bus.lo_z;
                    hi_x      <= on_bus.hi_x;
                    hi_y      <= on_bus.hi_y;
                    hi_z      <= on_bus.hi_z;
                    max_count <= on_bus.max_count;
                    send_idle = pace(send_calm);
                end
                in_valid <= launch;
            end
            hits_due <= hits_due + added;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        hit_report_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            recv_hold = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                hits_seen <= hits_seen + 1;
                if (expected_hits.size() == 0)
                begin
                    $error("result beat with nothing expected: slot_found %0d hit %0b",
                           slot_found, hit);
                    mismatches++;
                end
                else
                begin
                    want = expected_hits.pop_front();
                    if (slot_found !== want.slot_found)
                    begin
                        $error("slot_found: expected %0d, got %0d", want.slot_found,
                               slot_found);
                        mismatches++;
                    end
                    if (hit !== want.hit)
                    begin
                        $error("hit: expected %0b, got %0b", want.hit, hit);
                        mismatches++;
                    end
                    if (last !== want.last)
                    begin
                        $error("last: expected %0b, got %0b", want.last, last);
                        mismatches++;
                    end
                    if (count !== want.count)
                    begin
                        $error("count: expected %0d, got %0d", want.count, count);
                        mismatches++;
                    end
                end
                recv_hold = pace(recv_calm);
            end
            else if (out_valid && recv_hold > 0)
                recv_hold--;
            out_stall <= (recv_hold != 0);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL aabb_entity_overlap_table");
            $finish;
        end
    end

    initial
    begin
        table_op_t op;
        int        counted;
        int        pick;
        int        shape;
        rst_n = 1'b0;

        // directed: empty table, saturating corners, touching faces, limits
        push_uniform(ACT_QUERY,  10'd0,    24'sd0,    C_MIN,       C_MAX,     7'd10);
        push_uniform(ACT_LINK,   10'd0,    24'sd0,    -24'sd256,   24'sd256,  7'd0);
        push_uniform(ACT_LINK,   10'd1023, C_MAX,     C_MAX,       C_MAX,     7'd127);
        push_uniform(ACT_LINK,   10'd5,    C_MIN,     C_MIN,       C_MAX,     7'd0);
        push_uniform(ACT_LINK,   10'd7,    24'sd1000, 24'sd0,      24'sd0,    7'd0);
        push_uniform(ACT_LINK,   10'd512,  -24'sd1,   -24'sd1,     24'sd1,    7'd0);
        push_uniform(ACT_QUERY,  10'd1023, C_MAX,     C_MIN,       C_MAX,     7'd127);
        push_uniform(ACT_QUERY,  10'd0,    24'sd0,    24'sd256,    24'sd500,  7'd64);
        push_uniform(ACT_QUERY,  10'd0,    24'sd0,    C_MIN,       C_MAX,     7'd0);
        push_uniform(ACT_QUERY,  10'd0,    24'sd0,    C_MIN,       C_MAX,     7'd1);
        push_uniform(ACT_QUERY,  10'd0,    24'sd0,    24'sd300,    -24'sd300, 7'd64);
        push_uniform(ACT_UNLINK, 10'd0,    24'sd0,    24'sd0,      24'sd0,    7'd0);
        push_uniform(ACT_UNLINK, 10'd0,    24'sd0,    24'sd0,      24'sd0,    7'd0);
        push_uniform(ACT_SPARE,  10'd7,    C_MIN,     C_MIN,       C_MIN,     7'd127);
        push_uniform(ACT_LINK,   10'd5,    24'sd0,    24'sd0,      24'sd10,   7'd0);
        push_uniform(ACT_QUERY,  10'd0,    24'sd0,    24'sd0,      24'sd1000, 7'd64);
        push_uniform(ACT_QUERY,  10'd0,    24'sd0,    24'sd1000,   24'sd1000, 7'd2);
        push_uniform(ACT_QUERY,  10'd0,    24'sd0,    C_MIN,       C_MAX,     7'd64);
        push_uniform(ACT_QUERY,  10'd0,    24'sd0,    C_MAX,       C_MAX,     7'd3);
        push_uniform(ACT_UNLINK, 10'd512,  24'sd0,    24'sd0,      24'sd0,    7'd0);

        // random: mostly compact boxes in a shared region so queries find hits
        counted = 0;
        while (counted < RANDOM_OPS)
        begin
            op.action    = ACT_W'($urandom);
            op.slot      = SLOT_IN_W'($urandom);
            op.origin_x  = IN_W'($urandom);
            op.origin_y  = IN_W'($urandom);
            op.origin_z  = IN_W'($urandom);
            op.lo_x      = IN_W'($urandom);
            op.lo_y      = IN_W'($urandom);
            op.lo_z      = IN_W'($urandom);
            op.hi_x      = IN_W'($urandom);
            op.hi_y      = IN_W'($urandom);
            op.hi_z      = IN_W'($urandom);
            op.max_count = CNT_FW'($urandom);
            pick  = $urandom_range(0, 99);
            shape = $urandom_range(0, 99);
            if (pick < 45)
            begin
                op.action = ACT_LINK;
                if (shape < 75)
                    op.slot = SLOT_IN_W'($urandom_range(0, 95));
                if (shape < 80)
                begin
                    op.origin_x = coord_in(-3000, 3000);
                    op.origin_y = coord_in(-3000, 3000);
                    op.origin_z = coord_in(-3000, 3000);
                    op.lo_x     = coord_in(-800, 0);
                    op.lo_y     = coord_in(-800, 0);
                    op.lo_z     = coord_in(-800, 0);
                    op.hi_x     = coord_in(0, 800);
                    op.hi_y     = coord_in(0, 800);
                    op.hi_z     = coord_in(0, 800);
                end
            end
            else if (pick < 60)
            begin
                op.action = ACT_UNLINK;
                if (shape < 75)
                    op.slot = SLOT_IN_W'($urandom_range(0, 95));
            end
            else if (pick < 64)
                op.action = ACT_SPARE;
            else
            begin
                op.action = ACT_QUERY;
                if ($urandom_range(0, 4) != 0)
                    op.max_count = CNT_FW'($urandom_range(0, 70));
                if (shape < 65)
                begin
                    op.lo_x = coord_in(-4000, 1000);
                    op.lo_y = coord_in(-4000, 1000);
                    op.lo_z = coord_in(-4000, 1000);
                    op.hi_x = coord_in(-1000, 4000);
                    op.hi_y = coord_in(-1000, 4000);
                    op.hi_z = coord_in(-1000, 4000);
                end
                else if (shape < 80)
                begin
                    op.lo_x = C_MIN;
                    op.lo_y = C_MIN;
                    op.lo_z = C_MIN;
                    op.hi_x = C_MAX;
                    op.hi_y = C_MAX;
                    op.hi_z = C_MAX;
                end
            end
            op.drain = (counted == 0) || ($urandom_range(0, 39) == 0);
            ops_waiting.push_back(op);
            if (op.action != ACT_SPARE)
                counted++;
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (ops_waiting.size() != 0 || in_valid)
            @(posedge clk);
        while (hits_seen != hits_due)
            @(posedge clk);
        repeat (SLOTS + 64) @(posedge clk);
        if (expected_hits.size() != 0)
        begin
            $error("%0d hit reports never arrived", expected_hits.size());
            mismatches++;
        end

        if (mismatches == 0)
            $display("PASS aabb_entity_overlap_table");
        else
            $display("FAIL aabb_entity_overlap_table");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/aabb_eot_pkg.sv
hw/rtl/aabb_eot_ctrl.sv
hw/rtl/aabb_eot_dp.sv
hw/rtl/aabb_entity_overlap_table.sv
bench/tb.sv
